### hw/rtl/assert_macros.svh
// Assertion macros for the system register execute unit.
// Used by the top level; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold on every rising clock edge outside reset.
`define SREU_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define SREU_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

### hw/rtl/sreu_pkg.sv
// Shared types and constants for the system register execute unit.
// No dependencies.
package sreu_pkg;

  localparam int unsigned SPECIAL_COUNT = 1024;
  localparam int unsigned SEGMENT_COUNT = 16;
  localparam int unsigned SPR_W         = $clog2(SPECIAL_COUNT);
  localparam int unsigned SEG_W         = $clog2(SEGMENT_COUNT);
  localparam int unsigned QUEUE_DEPTH   = 2;

  localparam logic [31:0] RFI_COPY_MASK  = 32'h87C0_FF73;
  localparam logic [31:0] RFI_CLEAR_MASK = 32'h0004_0000;
  localparam logic [31:0] XER_TOP        = 32'hF000_0000;

  localparam logic [SPR_W-1:0] SPR_XER   = SPR_W'(1);
  localparam logic [SPR_W-1:0] SPR_SRR0  = SPR_W'(26);
  localparam logic [SPR_W-1:0] SPR_SRR1  = SPR_W'(27);
  localparam logic [SPR_W-1:0] SPR_TBL_W = SPR_W'(284);
  localparam logic [SPR_W-1:0] SPR_TBU_W = SPR_W'(285);
  localparam logic [SPR_W-1:0] TBR_TBL   = SPR_W'(268);
  localparam logic [SPR_W-1:0] TBR_TBU   = SPR_W'(269);

  localparam int unsigned TO_LT  = 4;
  localparam int unsigned TO_GT  = 3;
  localparam int unsigned TO_EQ  = 2;
  localparam int unsigned TO_ULT = 1;
  localparam int unsigned TO_UGT = 0;

  typedef enum logic [3:0] {
    OP_TRAP  = 4'd0,
    OP_SC    = 4'd1,
    OP_RFI   = 4'd2,
    OP_MTCRF = 4'd3,
    OP_MCRXR = 4'd4,
    OP_MFCR  = 4'd5,
    OP_MTMSR = 4'd6,
    OP_MFMSR = 4'd7,
    OP_MTSPR = 4'd8,
    OP_MFSPR = 4'd9,
    OP_MFTB  = 4'd10,
    OP_MTSR  = 4'd11,
    OP_MFSR  = 4'd12
  } op_e;

  typedef enum logic [1:0] {
    SPRK_XER   = 2'd0,
    SPRK_SRR0  = 2'd1,
    SPRK_SRR1  = 2'd2,
    SPRK_OTHER = 2'd3
  } spr_kind_e;

  typedef enum logic [1:0] {
    EXC_NONE = 2'd0,
    EXC_TRAP = 2'd1,
    EXC_SC   = 2'd2
  } exc_e;

  // Classified instruction as held in the queue
  typedef struct packed {
    op_e              op;
    logic             trap_hit;
    spr_kind_e        spr_kind;
    logic [SPR_W-1:0] spr;
    logic [SEG_W-1:0] seg;
    logic [31:0]      src;
    logic [7:0]       crm;
    logic [2:0]       crf;
    logic [31:0]      pc;
  } sreu_item_t;

  typedef struct packed {
    logic [31:0] dest_value;
    logic        dest_write;
    exc_e        exception;
    logic        redirect;
    logic [31:0] next_pc;
  } sreu_result_t;

endpackage

### hw/rtl/system_register_execute_unit.sv
// Path: an input transaction passes the queue slot, execute stage and output register,
// each registered, before the result is valid.
// Throughput: one instruction per cycle while the output is not stalled and the store
// is not clearing; the special store read issues as an instruction leaves the queue.
// Reset: registers clear at once; the 1024-entry special store is then cleared one
// entry a cycle with s_axis_tready low; configuration writes are taken.
`include "assert_macros.svh"
module system_register_execute_unit (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic         cfg_data_i,     // syscall_blocked
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // op[3:0] a_value[35:4] b_value[67:36] source_value[99:68] trap_conditions[104:100]
  // field_mask[112:105] cr_field[115:113] spr_number[125:116] segment_index[129:126]
  // pc[161:130], zero fill above
  input  logic [167:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // dest_value[31:0] dest_write[32] exception[34:33] redirect[35] next_pc[67:36],
  // zero fill above
  output logic [71:0]  m_axis_tdata
);

  logic                   push;
  logic                   q_ready;
  logic                   q_valid;
  logic                   pop;
  logic                   clearing;
  sreu_pkg::sreu_item_t   front_item;
  sreu_pkg::sreu_item_t   q_item;
  sreu_pkg::sreu_result_t result;

  assign cfg_ready_o = 1'b1;

  sreu_front u_front (
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .q_ready_i     (q_ready),
    .clearing_i    (clearing),
    .push_o        (push),
    .item_o        (front_item)
  );

  sreu_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (front_item),
    .ready_o (q_ready),
    .pop_i   (pop),
    .valid_o (q_valid),
    .item_o  (q_item)
  );

  sreu_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .q_valid_i   (q_valid),
    .q_item_i    (q_item),
    .pop_o       (pop),
    .clearing_o  (clearing),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_o       (result)
  );

  assign m_axis_tdata = {4'b0000, result.next_pc, result.redirect, result.exception,
                         result.dest_write, result.dest_value};

  `SREU_ASSERT(a_no_accept_clearing, clk_i, rst_ni, !(push && clearing),
               "transaction accepted during store clear")
  `SREU_ASSERT(a_no_pop_empty, clk_i, rst_ni, !(pop && !q_valid), "queue popped while empty")
  `SREU_ASSERT_IMP(a_redirect_clean, clk_i, rst_ni, m_axis_tvalid && result.redirect,
                   (result.exception == sreu_pkg::EXC_NONE) && !result.dest_write,
                   "redirect with exception or write")
  `SREU_ASSERT_IMP(a_write_no_exc, clk_i, rst_ni, m_axis_tvalid && result.dest_write,
                   result.exception == sreu_pkg::EXC_NONE, "register write with exception")

endmodule

### hw/rtl/sreu_front.sv
// Front end: unpacks input transactions, evaluates the trap compare and
// classifies the special register number. Depends on sreu_pkg.
module sreu_front (
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [167:0]         s_axis_tdata,
  input  logic                 q_ready_i,
  input  logic                 clearing_i,
  output logic                 push_o,
  output sreu_pkg::sreu_item_t item_o
);

  logic [31:0]              a_val;
  logic [31:0]              b_val;
  logic [4:0]               to_mask;
  logic [sreu_pkg::SPR_W-1:0] spr;

  assign a_val   = s_axis_tdata[35:4];
  assign b_val   = s_axis_tdata[67:36];
  assign to_mask = s_axis_tdata[104:100];
  assign spr     = s_axis_tdata[125:116];

  assign s_axis_tready = q_ready_i && !clearing_i;
  assign push_o        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    item_o.op  = sreu_pkg::op_e'(s_axis_tdata[3:0]);
    item_o.src = s_axis_tdata[99:68];
    item_o.crm = s_axis_tdata[112:105];
    item_o.crf = s_axis_tdata[115:113];
    item_o.spr = spr;
    item_o.seg = s_axis_tdata[129:126];
    item_o.pc  = s_axis_tdata[161:130];

    item_o.trap_hit =
        (to_mask[sreu_pkg::TO_LT]  && ($signed(a_val) < $signed(b_val))) ||
        (to_mask[sreu_pkg::TO_GT]  && ($signed(a_val) > $signed(b_val))) ||
        (to_mask[sreu_pkg::TO_EQ]  && (a_val == b_val)) ||
        (to_mask[sreu_pkg::TO_ULT] && (a_val < b_val)) ||
        (to_mask[sreu_pkg::TO_UGT] && (a_val > b_val));

    if (spr == sreu_pkg::SPR_XER) begin
      item_o.spr_kind = sreu_pkg::SPRK_XER;
    end else if (spr == sreu_pkg::SPR_SRR0) begin
      item_o.spr_kind = sreu_pkg::SPRK_SRR0;
    end else if (spr == sreu_pkg::SPR_SRR1) begin
      item_o.spr_kind = sreu_pkg::SPRK_SRR1;
    end else begin
      item_o.spr_kind = sreu_pkg::SPRK_OTHER;
    end
  end

endmodule

### hw/rtl/sreu_queue.sv
// Short FIFO of classified instructions between front and back end.
// Depends on sreu_pkg.
module sreu_queue (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  sreu_pkg::sreu_item_t item_i,
  output logic                 ready_o,
  input  logic                 pop_i,
  output logic                 valid_o,
  output sreu_pkg::sreu_item_t item_o
);

  localparam int unsigned PTR_W = $clog2(sreu_pkg::QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(sreu_pkg::QUEUE_DEPTH + 1);

  sreu_pkg::sreu_item_t slot_q [sreu_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;

  assign ready_o = (count_q != CNT_W'(sreu_pkg::QUEUE_DEPTH));
  assign valid_o = (count_q != '0);
  assign item_o  = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(sreu_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(sreu_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

### hw/rtl/sreu_back.sv
// Back end: architectural registers, special register store, execute stage
// and output register. Depends on sreu_pkg.
module sreu_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  input  logic                 cfg_data_i,
  input  logic                 q_valid_i,
  input  sreu_pkg::sreu_item_t q_item_i,
  output logic                 pop_o,
  output logic                 clearing_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output sreu_pkg::sreu_result_t out_o
);

  localparam int unsigned SPR_W = sreu_pkg::SPR_W;

  // store clearing pass after reset
  logic             clearing_q, clearing_d;
  logic [SPR_W-1:0] clr_cnt_q, clr_cnt_d;

  logic syscall_blocked_q;

  // execute stage
  logic                 s1_valid_q, s1_valid_d;
  sreu_pkg::sreu_item_t s1_q;
  logic                 s1_fire;

  // store read data plus forwarding from the instruction ahead
  logic [31:0] mem_rdata_q;
  logic        byp_q;
  logic [31:0] byp_val_q;
  logic [31:0] spr_rd;
  logic [31:0] spr_mem [sreu_pkg::SPECIAL_COUNT];
  logic             mem_we;
  logic [SPR_W-1:0] mem_waddr;
  logic [31:0]      mem_wdata;
  logic             exec_mem_we;

  logic [31:0] cr_q, cr_d;
  logic [31:0] msr_q, msr_d;
  logic [31:0] xer_q, xer_d;
  logic [31:0] srr0_q, srr0_d;
  logic [31:0] srr1_q, srr1_d;
  logic [31:0] tbl_q, tbl_d;
  logic [31:0] tbu_q, tbu_d;
  logic [31:0] seg_q [sreu_pkg::SEGMENT_COUNT];
  logic        seg_we;
  logic [31:0] xer_shift_mask;
  logic [31:0] pc_plus4;

  logic                   out_valid_q, out_valid_d;
  sreu_pkg::sreu_result_t out_q, res;

  assign clearing_o  = clearing_q;
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  assign s1_fire = s1_valid_q && (!out_valid_q || out_ready_i);
  assign pop_o   = q_valid_i && (!s1_valid_q || s1_fire);
  assign spr_rd  = byp_q ? byp_val_q : mem_rdata_q;
  assign pc_plus4 = s1_q.pc + 32'd4;
  assign xer_shift_mask = sreu_pkg::XER_TOP >> {s1_q.crf, 2'b00};

  always_comb begin
    clearing_d = clearing_q;
    clr_cnt_d  = clr_cnt_q;
    if (clearing_q) begin
      clr_cnt_d = clr_cnt_q + 1'b1;
      if (clr_cnt_q == SPR_W'(sreu_pkg::SPECIAL_COUNT - 1)) begin
        clearing_d = 1'b0;
      end
    end
  end

  // execute
  always_comb begin
    cr_d   = cr_q;
    msr_d  = msr_q;
    xer_d  = xer_q;
    srr0_d = srr0_q;
    srr1_d = srr1_q;
    tbl_d  = tbl_q;
    tbu_d  = tbu_q;
    seg_we = 1'b0;
    exec_mem_we    = 1'b0;
    res.dest_value = '0;
    res.dest_write = 1'b0;
    res.exception  = sreu_pkg::EXC_NONE;
    res.redirect   = 1'b0;
    res.next_pc    = '0;
    case (s1_q.op)
      sreu_pkg::OP_TRAP: begin
        if (s1_q.trap_hit) begin
          res.exception = sreu_pkg::EXC_TRAP;
          res.next_pc   = pc_plus4;
        end
      end
      sreu_pkg::OP_SC: begin
        if (!syscall_blocked_q) begin
          res.exception = sreu_pkg::EXC_SC;
          res.next_pc   = pc_plus4;
        end
      end
      sreu_pkg::OP_RFI: begin
        msr_d = (msr_q & ~(sreu_pkg::RFI_COPY_MASK | sreu_pkg::RFI_CLEAR_MASK)) |
                (srr1_q & sreu_pkg::RFI_COPY_MASK);
        res.next_pc  = {srr0_q[31:2], 2'b00};
        res.redirect = 1'b1;
      end
      sreu_pkg::OP_MTCRF: begin
        for (int i = 0; i < 8; i++) begin
          if (s1_q.crm[i]) begin
            cr_d[4*i +: 4] = s1_q.src[4*i +: 4];
          end
        end
      end
      sreu_pkg::OP_MCRXR: begin
        cr_d  = (cr_q & ~xer_shift_mask) |
                ((xer_q & sreu_pkg::XER_TOP) >> {s1_q.crf, 2'b00});
        xer_d = xer_q & ~sreu_pkg::XER_TOP;
      end
      sreu_pkg::OP_MFCR: begin
        res.dest_value = cr_q;
        res.dest_write = 1'b1;
      end
      sreu_pkg::OP_MTMSR: msr_d = s1_q.src;
      sreu_pkg::OP_MFMSR: begin
        res.dest_value = msr_q;
        res.dest_write = 1'b1;
      end
      sreu_pkg::OP_MTSPR: begin
        case (s1_q.spr_kind)
          sreu_pkg::SPRK_XER:  xer_d  = s1_q.src;
          sreu_pkg::SPRK_SRR0: srr0_d = s1_q.src;
          sreu_pkg::SPRK_SRR1: srr1_d = s1_q.src;
          default: begin
            exec_mem_we = 1'b1;
            if (s1_q.spr == sreu_pkg::SPR_TBL_W) begin
              tbl_d = s1_q.src;
            end else if (s1_q.spr == sreu_pkg::SPR_TBU_W) begin
              tbu_d = s1_q.src;
            end
          end
        endcase
      end
      sreu_pkg::OP_MFSPR: begin
        case (s1_q.spr_kind)
          sreu_pkg::SPRK_XER:  res.dest_value = xer_q;
          sreu_pkg::SPRK_SRR0: res.dest_value = srr0_q;
          sreu_pkg::SPRK_SRR1: res.dest_value = srr1_q;
          default:             res.dest_value = spr_rd;
        endcase
        res.dest_write = 1'b1;
      end
      sreu_pkg::OP_MFTB: begin
        if (s1_q.spr == sreu_pkg::TBR_TBL) begin
          res.dest_value = tbl_q;
          res.dest_write = 1'b1;
        end else if (s1_q.spr == sreu_pkg::TBR_TBU) begin
          res.dest_value = tbu_q;
          res.dest_write = 1'b1;
        end
      end
      sreu_pkg::OP_MTSR: seg_we = 1'b1;
      sreu_pkg::OP_MFSR: begin
        res.dest_value = seg_q[s1_q.seg];
        res.dest_write = 1'b1;
      end
      default: ;
    endcase
  end

  assign mem_we    = clearing_q || (s1_fire && exec_mem_we);
  assign mem_waddr = clearing_q ? clr_cnt_q : s1_q.spr;
  assign mem_wdata = clearing_q ? '0 : s1_q.src;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (pop_o) begin
      s1_valid_d = 1'b1;
    end else if (s1_fire) begin
      s1_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (s1_fire) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clearing_q        <= 1'b1;
      clr_cnt_q         <= '0;
      syscall_blocked_q <= 1'b0;
      s1_valid_q        <= 1'b0;
      out_valid_q       <= 1'b0;
      cr_q   <= '0;
      msr_q  <= '0;
      xer_q  <= '0;
      srr0_q <= '0;
      srr1_q <= '0;
      tbl_q  <= '0;
      tbu_q  <= '0;
      for (int i = 0; i < sreu_pkg::SEGMENT_COUNT; i++) begin
        seg_q[i] <= '0;
      end
    end else begin
      clearing_q  <= clearing_d;
      clr_cnt_q   <= clr_cnt_d;
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i) begin
        syscall_blocked_q <= cfg_data_i;
      end
      if (s1_fire) begin
        cr_q   <= cr_d;
        msr_q  <= msr_d;
        xer_q  <= xer_d;
        srr0_q <= srr0_d;
        srr1_q <= srr1_d;
        tbl_q  <= tbl_d;
        tbu_q  <= tbu_d;
        if (seg_we) begin
          seg_q[s1_q.seg] <= s1_q.src;
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      s1_q        <= q_item_i;
      mem_rdata_q <= spr_mem[q_item_i.spr];
      // store write from the instruction ahead lands this edge; forward it
      byp_q       <= s1_fire && exec_mem_we && (s1_q.spr == q_item_i.spr);
      byp_val_q   <= s1_q.src;
    end
    if (s1_fire) begin
      out_q <= res;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      spr_mem[mem_waddr] <= mem_wdata;
    end
  end

endmodule

### tb/tb_system_register_execute_unit.sv
// Self-checking testbench for system_register_execute_unit: directed table, then random
// instruction streams under several idling patterns, checked against a local predictor.
// Depends on sreu_pkg and the unit's RTL only.
`timescale 1ns / 1ps
module tb_system_register_execute_unit;

  localparam logic [3:0] OP_RESERVED_FIRST = 4'd13;
  localparam logic [3:0] OP_RESERVED_LAST  = 4'd15;
  localparam int unsigned PIPE_LATENCY     = 3;
  localparam int unsigned ITEMS_PER_PHASE  = 112;

  typedef struct packed {
    logic [3:0]                 op;
    logic [31:0]                a;
    logic [31:0]                b;
    logic [31:0]                src;
    logic [4:0]                 trap_to;
    logic [7:0]                 crm;
    logic [2:0]                 crf;
    logic [sreu_pkg::SPR_W-1:0] spr;
    logic [sreu_pkg::SEG_W-1:0] seg;
    logic [31:0]                pc;
  } instr_t;

  typedef struct {
    instr_t                 it;
    bit                     typed;
    sreu_pkg::sreu_result_t res;
    bit                     cfg_change;
    bit                     cfg_value;
  } dir_row_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         cfg_valid_i = 1'b0;
  logic         cfg_ready_o;
  logic         cfg_data_i = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  // op, a_value, b_value, source_value, trap_conditions, field_mask, cr_field,
  // spr_number, segment_index, pc, zero fill
  logic [167:0] s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  // dest_value, dest_write, exception, redirect, next_pc, zero fill
  logic [71:0]  m_axis_tdata;

  system_register_execute_unit uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Predictor state, mirrors the architectural registers of the unit
  bit [31:0] cond_reg, msr_reg, xer_reg, srr0_reg, srr1_reg, tb_lower, tb_upper;
  bit [31:0] seg_regs [sreu_pkg::SEGMENT_COUNT];
  bit [31:0] spr_regs [sreu_pkg::SPECIAL_COUNT];
  bit        syscall_blocked;

  sreu_pkg::sreu_result_t pending_results [$];
  dir_row_t               directed_rows [$];
  int                     mismatch_count = 0;
  int                     idle_pct = 0;
  int                     stall_pct = 0;

  function automatic sreu_pkg::sreu_result_t execute_system_op(instr_t it);
    sreu_pkg::sreu_result_t r;
    logic signed [31:0]     sa, sb;
    bit                     hit;
    int                     base;
    r = '0;
    case (it.op)
      sreu_pkg::OP_TRAP: begin
        sa = it.a;
        sb = it.b;
        hit = (it.trap_to[sreu_pkg::TO_LT] && sa < sb) ||
              (it.trap_to[sreu_pkg::TO_GT] && sa > sb) ||
              (it.trap_to[sreu_pkg::TO_EQ] && it.a == it.b) ||
              (it.trap_to[sreu_pkg::TO_ULT] && it.a < it.b) ||
              (it.trap_to[sreu_pkg::TO_UGT] && it.a > it.b);
        if (hit) begin
          r.exception = sreu_pkg::EXC_TRAP;
          r.next_pc   = it.pc + 32'd4;
        end
      end
      sreu_pkg::OP_SC: begin
        if (!syscall_blocked) begin
          r.exception = sreu_pkg::EXC_SC;
          r.next_pc   = it.pc + 32'd4;
        end
      end
      sreu_pkg::OP_RFI: begin
        msr_reg    = (msr_reg & ~(sreu_pkg::RFI_COPY_MASK | sreu_pkg::RFI_CLEAR_MASK)) |
                     (srr1_reg & sreu_pkg::RFI_COPY_MASK);
        r.next_pc  = {srr0_reg[31:2], 2'b00};
        r.redirect = 1'b1;
      end
      sreu_pkg::OP_MTCRF: begin
        for (int i = 0; i < 8; i++)
          if (it.crm[i]) cond_reg[4*i +: 4] = it.src[4*i +: 4];
      end
      sreu_pkg::OP_MCRXR: begin
        // field 0 is the top nibble
        base = 28 - 4 * int'(it.crf);
        cond_reg[base +: 4] = xer_reg[31:28];
        xer_reg[31:28] = 4'h0;
      end
      sreu_pkg::OP_MFCR: begin
        r.dest_value = cond_reg;
        r.dest_write = 1'b1;
      end
      sreu_pkg::OP_MTMSR: msr_reg = it.src;
      sreu_pkg::OP_MFMSR: begin
        r.dest_value = msr_reg;
        r.dest_write = 1'b1;
      end
      sreu_pkg::OP_MTSPR: begin
        case (it.spr)
          sreu_pkg::SPR_XER:  xer_reg = it.src;
          sreu_pkg::SPR_SRR0: srr0_reg = it.src;
          sreu_pkg::SPR_SRR1: srr1_reg = it.src;
          default: begin
            if (it.spr == sreu_pkg::SPR_TBL_W) tb_lower = it.src;
            else if (it.spr == sreu_pkg::SPR_TBU_W) tb_upper = it.src;
            spr_regs[it.spr] = it.src;
          end
        endcase
      end
      sreu_pkg::OP_MFSPR: begin
        case (it.spr)
          sreu_pkg::SPR_XER:  r.dest_value = xer_reg;
          sreu_pkg::SPR_SRR0: r.dest_value = srr0_reg;
          sreu_pkg::SPR_SRR1: r.dest_value = srr1_reg;
          default:            r.dest_value = spr_regs[it.spr];
        endcase
        r.dest_write = 1'b1;
      end
      sreu_pkg::OP_MFTB: begin
        if (it.spr == sreu_pkg::TBR_TBL) begin
          r.dest_value = tb_lower;
          r.dest_write = 1'b1;
        end else if (it.spr == sreu_pkg::TBR_TBU) begin
          r.dest_value = tb_upper;
          r.dest_write = 1'b1;
        end
      end
      sreu_pkg::OP_MTSR: seg_regs[it.seg] = it.src;
      sreu_pkg::OP_MFSR: begin
        r.dest_value = seg_regs[it.seg];
        r.dest_write = 1'b1;
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic instr_t make_instr(logic [3:0] op, logic [31:0] a, logic [31:0] b,
                                        logic [31:0] src, logic [4:0] trap_to,
                                        logic [7:0] crm, logic [2:0] crf,
                                        logic [sreu_pkg::SPR_W-1:0] spr,
                                        logic [sreu_pkg::SEG_W-1:0] seg,
                                        logic [31:0] pc);
    instr_t it;
    it.op = op; it.a = a; it.b = b; it.src = src; it.trap_to = trap_to;
    it.crm = crm; it.crf = crf; it.spr = spr; it.seg = seg; it.pc = pc;
    return it;
  endfunction

  function automatic sreu_pkg::sreu_result_t outcome(logic [31:0] dv, logic dw,
                                                     sreu_pkg::exc_e exc,
                                                     logic rd, logic [31:0] npc);
    sreu_pkg::sreu_result_t r;
    r.dest_value = dv; r.dest_write = dw; r.exception = exc;
    r.redirect = rd; r.next_pc = npc;
    return r;
  endfunction

  function automatic instr_t random_instr();
    instr_t it;
    int     k;
    it.op = 4'($urandom_range(sreu_pkg::OP_TRAP, sreu_pkg::OP_MFSR));
    if ($urandom_range(0, 99) < 5)
      it.op = 4'($urandom_range(OP_RESERVED_FIRST, OP_RESERVED_LAST));
    it.a       = $urandom;
    it.b       = $urandom;
    it.src     = $urandom;
    it.trap_to = 5'($urandom);
    it.crm     = 8'($urandom);
    it.crf     = 3'($urandom);
    it.seg     = sreu_pkg::SEG_W'($urandom);
    it.pc      = $urandom;
    // keep most register numbers on a small pool so reads find earlier writes
    k = $urandom_range(0, 99);
    if (k < 40) begin
      case ($urandom_range(0, 6))
        0: it.spr = sreu_pkg::SPR_XER;
        1: it.spr = sreu_pkg::SPR_SRR0;
        2: it.spr = sreu_pkg::SPR_SRR1;
        3: it.spr = sreu_pkg::SPR_TBL_W;
        4: it.spr = sreu_pkg::SPR_TBU_W;
        5: it.spr = sreu_pkg::TBR_TBL;
        default: it.spr = sreu_pkg::TBR_TBU;
      endcase
    end else if (k < 75) begin
      it.spr = sreu_pkg::SPR_W'($urandom_range(0, 15));
    end else begin
      it.spr = sreu_pkg::SPR_W'($urandom);
    end
    if (it.op == sreu_pkg::OP_MFTB && $urandom_range(0, 99) < 70)
      it.spr = $urandom_range(0, 1) ? sreu_pkg::TBR_TBL : sreu_pkg::TBR_TBU;
    k = $urandom_range(0, 99);
    if (k < 25) it.b = it.a;
    else if (k < 45) it.b = it.a + 32'($urandom_range(0, 2)) - 32'd1;
    return it;
  endfunction

  task automatic add_row(instr_t it, bit typed = 1'b0, sreu_pkg::sreu_result_t res = '0,
                         bit cfg_change = 1'b0, bit cfg_value = 1'b0);
    dir_row_t row;
    row.it = it; row.typed = typed; row.res = res;
    row.cfg_change = cfg_change; row.cfg_value = cfg_value;
    directed_rows.push_back(row);
  endtask

  task automatic check_field(string name, logic [31:0] want_v, logic [31:0] got_v);
    if (want_v !== got_v) begin
      $display("%0t: %s mismatch, expected %h actual %h", $time, name, want_v, got_v);
      mismatch_count++;
    end
  endtask

  task automatic send_instr(instr_t it, bit typed, sreu_pkg::sreu_result_t res);
    sreu_pkg::sreu_result_t pred;
    if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {6'b0, it.pc, it.seg, it.spr, it.crf, it.crm, it.trap_to,
                      it.src, it.b, it.a, it.op};
    do @(posedge clk_i); while (!s_axis_tready);
    pred = execute_system_op(it);
    pending_results.push_back(typed ? res : pred);
  endtask

  // Wait until the unit has returned everything it owes, then let the pipe settle
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (PIPE_LATENCY) @(posedge clk_i);
  endtask

  task automatic write_cfg(bit value);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    syscall_blocked = value;
  endtask

  always @(posedge clk_i) begin : result_monitor
    sreu_pkg::sreu_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result transaction, expected none actual %h",
                 $time, m_axis_tdata);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("dest_value", want.dest_value, m_axis_tdata[31:0]);
        check_field("dest_write", 32'(want.dest_write), 32'(m_axis_tdata[32]));
        check_field("exception", 32'(want.exception), 32'(m_axis_tdata[34:33]));
        check_field("redirect", 32'(want.redirect), 32'(m_axis_tdata[35]));
        check_field("next_pc", want.next_pc, m_axis_tdata[67:36]);
      end
    end
    m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
  end

  initial begin
    #2_000_000;
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    // reset state, extremes and odd codes
    add_row(make_instr(sreu_pkg::OP_MFCR, 0, 0, 0, 0, 0, 0, 0, 0, 32'h100), 1,
            outcome(0, 1, sreu_pkg::EXC_NONE, 0, 0));
    add_row(make_instr(sreu_pkg::OP_MFMSR, 0, 0, 0, 0, 0, 0, 0, 0, 32'h104), 1,
            outcome(0, 1, sreu_pkg::EXC_NONE, 0, 0));
    add_row(make_instr(sreu_pkg::OP_MFSPR, 0, 0, 0, 0, 0, 0, 10'h3FF, 0, 32'h108), 1,
            outcome(0, 1, sreu_pkg::EXC_NONE, 0, 0));
    add_row(make_instr(sreu_pkg::OP_MFTB, 0, 0, 0, 0, 0, 0, sreu_pkg::TBR_TBU, 0,
                       32'h10C), 1, outcome(0, 1, sreu_pkg::EXC_NONE, 0, 0));
    // unknown time base number writes nothing
    add_row(make_instr(sreu_pkg::OP_MFTB, 0, 0, 0, 0, 0, 0, 0, 0, 32'h110), 1,
            outcome(0, 0, sreu_pkg::EXC_NONE, 0, 0));
    add_row(make_instr(OP_RESERVED_LAST, '1, '1, '1, '1, '1, '1, '1, '1, '1), 1,
            outcome(0, 0, sreu_pkg::EXC_NONE, 0, 0));
    // traps on the LT, GT, UGT and EQ compares, next_pc wraps at the top of the address space
    add_row(make_instr(sreu_pkg::OP_TRAP, 32'h8000_0000, 32'h7FFF_FFFF, 0,
                       5'(1 << sreu_pkg::TO_LT), 0, 0, 0, 0, 32'hFFFF_FFFC), 1,
            outcome(0, 0, sreu_pkg::EXC_TRAP, 0, 0));
    add_row(make_instr(sreu_pkg::OP_TRAP, 32'h7FFF_FFFF, 32'h8000_0000, 0,
                       5'(1 << sreu_pkg::TO_GT), 0, 0, 0, 0, 0), 1,
            outcome(0, 0, sreu_pkg::EXC_TRAP, 0, 32'd4));
    add_row(make_instr(sreu_pkg::OP_TRAP, 32'hFFFF_FFFF, 0, 0,
                       5'(1 << sreu_pkg::TO_UGT), 0, 0, 0, 0, 32'h200), 1,
            outcome(0, 0, sreu_pkg::EXC_TRAP, 0, 32'h204));
    add_row(make_instr(sreu_pkg::OP_TRAP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0,
                       5'(1 << sreu_pkg::TO_EQ), 0, 0, 0, 0, 32'h300), 1,
            outcome(0, 0, sreu_pkg::EXC_TRAP, 0, 32'h304));
    add_row(make_instr(sreu_pkg::OP_SC, 0, 0, 0, 0, 0, 0, 0, 0, 32'h1000), 1,
            outcome(0, 0, sreu_pkg::EXC_SC, 0, 32'h1004));
    add_row(make_instr(sreu_pkg::OP_MTCRF, 0, 0, 32'hFFFF_FFFF, 0, 8'hA5, 0, 0, 0, 0), 1,
            outcome(0, 0, sreu_pkg::EXC_NONE, 0, 0));
    add_row(make_instr(sreu_pkg::OP_MTSPR, 0, 0, 32'hF000_0000, 0, 0, 0,
                       sreu_pkg::SPR_XER, 0, 0));
    add_row(make_instr(sreu_pkg::OP_MCRXR, 0, 0, 0, 0, 0, 3'd7, 0, 0, 0));
    add_row(make_instr(sreu_pkg::OP_MFCR, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    add_row(make_instr(sreu_pkg::OP_MTSPR, 0, 0, 32'hFFFF_FFFF, 0, 0, 0,
                       sreu_pkg::SPR_SRR0, 0, 0));
    add_row(make_instr(sreu_pkg::OP_MTSPR, 0, 0, 32'hFFFF_FFFF, 0, 0, 0,
                       sreu_pkg::SPR_SRR1, 0, 0));
    add_row(make_instr(sreu_pkg::OP_RFI, 0, 0, 0, 0, 0, 0, 0, 0, 32'h400), 1,
            outcome(0, 0, sreu_pkg::EXC_NONE, 1, 32'hFFFF_FFFC));
    add_row(make_instr(sreu_pkg::OP_MFMSR, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    // time base write goes to both the counter half and the store entry
    add_row(make_instr(sreu_pkg::OP_MTSPR, 0, 0, 32'h1234_5678, 0, 0, 0,
                       sreu_pkg::SPR_TBL_W, 0, 0));
    add_row(make_instr(sreu_pkg::OP_MFTB, 0, 0, 0, 0, 0, 0, sreu_pkg::TBR_TBL, 0, 0));
    add_row(make_instr(sreu_pkg::OP_MTSR, 0, 0, 32'hDEAD_BEEF, 0, 0, 0, 0, 4'hF, 0));
    add_row(make_instr(sreu_pkg::OP_MFSR, 0, 0, 0, 0, 0, 0, 0, 4'hF, 0));
    // syscall with the block set has no effect at all
    add_row(make_instr(sreu_pkg::OP_SC, 0, 0, 0, 0, 0, 0, 0, 0, 32'h2000), 1,
            outcome(0, 0, sreu_pkg::EXC_NONE, 0, 0), 1, 1);

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    write_cfg(1'b0);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].cfg_change) begin
        drain_results();
        write_cfg(directed_rows[i].cfg_value);
      end
      send_instr(directed_rows[i].it, directed_rows[i].typed, directed_rows[i].res);
    end

    for (int ph = 0; ph < 4; ph++) begin
      drain_results();
      write_cfg(ph[0]);
      case (ph)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 46; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 46; end
        default: begin idle_pct = 16; stall_pct = 16; end
      endcase
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (ph == 1 && n == ITEMS_PER_PHASE / 2) drain_results();
        send_instr(random_instr(), 1'b0, '0);
      end
    end
    drain_results();

    if (mismatch_count == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
